// ===== hdl/assert_macros.svh =====
// assertion macros used by the canvas rasterizer back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked on every rising edge outside reset
`define CRC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, checked on every rising edge outside reset
`define CRC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define CRC_ASSERT_IMP(lbl, ante, cons)

`define CRC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== hdl/crc_pkg.sv =====
// shared constants and types of the circle raster canvas
package crc_pkg;

	// canvas geometry
	localparam int MAX_SIDE  = 256;
	localparam int SIDE_W    = $clog2(MAX_SIDE);
	localparam int ADDR_W    = 2 * SIDE_W;
	localparam int MEM_DEPTH = MAX_SIDE * MAX_SIDE;

	// configuration port
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 2'd2;
	localparam logic [7:0] BACKGROUND_RESET = 8'd32;

	// fixed point arithmetic, Q.8 coordinates and Q.16 squares
	localparam int COORD_W = 19;
	localparam int DXY_W   = 20;
	localparam int SQ_W    = 37;
	localparam int D2_W    = 38;
	localparam int ONE_Q8  = 256;

	// command queue
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// item opcodes and shape kinds
	localparam logic [1:0] OP_CLEAR      = 2'd0;
	localparam logic [1:0] OP_DRAW       = 2'd1;
	localparam logic [1:0] OP_READ       = 2'd2;
	localparam logic [1:0] SHAPE_OUTLINE = 2'd0;
	localparam logic [1:0] SHAPE_FILLED  = 2'd1;

	// work classes handed from the front to the back
	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_CLEAR,
		CMD_DRAW,
		CMD_READ
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                  kind;
		logic                       outline;
		logic                       bad;
		logic signed [COORD_W-1:0]  cx;
		logic signed [COORD_W-1:0]  cy;
		logic signed [COORD_W-1:0]  radius;
		logic [7:0]                 color;
		logic [SIDE_W-1:0]          col;
		logic [SIDE_W-1:0]          row;
		logic [SIDE_W-1:0]          w_last;
		logic [SIDE_W-1:0]          h_last;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// back end sequencer states
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_SWEEP,
		BK_DRAIN,
		BK_READ,
		BK_FINISH
	} back_state_t;

endpackage

// ===== hdl/crc_front.sv =====
// front end: configuration registers, item intake and classification
module crc_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [1:0]                          op,
	input  logic [1:0]                          shape_kind,
	input  logic signed [crc_pkg::COORD_W-1:0]  center_x,
	input  logic signed [crc_pkg::COORD_W-1:0]  center_y,
	input  logic signed [crc_pkg::COORD_W-1:0]  radius,
	input  logic [7:0]                          color,
	input  logic [crc_pkg::SIDE_W-1:0]          pixel_column,
	input  logic [crc_pkg::SIDE_W-1:0]          pixel_row,
	input  logic                                cfg_wr_en,
	input  logic [crc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [crc_pkg::CFG_W-1:0]           cfg_data,
	input  crc_pkg::q_status_t                  q_status,
	output logic                                busy,
	output logic                                push,
	output crc_pkg::cmd_t                       push_cmd
);
	import crc_pkg::*;

	logic [CFG_W-1:0]  width_q;
	logic [CFG_W-1:0]  height_q;
	logic [7:0]        background_q;
	logic [SIDE_W-1:0] w_last;
	logic [SIDE_W-1:0] h_last;

	// last column or row in use, size clamped to 1..MAX_SIDE
	function automatic logic [SIDE_W-1:0] side_last(input logic [CFG_W-1:0] v);
		if (v == '0)
			return '0;
		else if (v > CFG_W'(MAX_SIDE))
			return SIDE_W'(MAX_SIDE - 1);
		else
			return SIDE_W'(v - 1'b1);
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q      <= CFG_W'(1);
			height_q     <= CFG_W'(1);
			background_q <= BACKGROUND_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_WIDTH:      width_q      <= cfg_data;
				CFG_HEIGHT:     height_q     <= cfg_data;
				CFG_BACKGROUND: background_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign w_last = side_last(width_q);
	assign h_last = side_last(height_q);

	// intake handshake: hold off only when the queue is full
	assign busy = q_status.full;
	assign push = start && !busy;

	// classify the item into a queue entry
	always_comb begin
		push_cmd         = '0;
		push_cmd.kind    = CMD_NONE;
		push_cmd.outline = (shape_kind == SHAPE_OUTLINE);
		push_cmd.cx      = center_x;
		push_cmd.cy      = center_y;
		push_cmd.radius  = radius;
		push_cmd.color   = color;
		push_cmd.col     = pixel_column;
		push_cmd.row     = pixel_row;
		push_cmd.w_last  = w_last;
		push_cmd.h_last  = h_last;
		case (op)
			OP_CLEAR: begin
				push_cmd.kind  = CMD_CLEAR;
				push_cmd.color = background_q;
			end
			OP_DRAW: begin
				if (radius[COORD_W-1] || radius == '0)
					push_cmd.bad = 1'b1;
				else if (shape_kind inside {SHAPE_OUTLINE, SHAPE_FILLED})
					push_cmd.kind = CMD_DRAW;
			end
			OP_READ: begin
				if (pixel_column <= w_last && pixel_row <= h_last)
					push_cmd.kind = CMD_READ;
			end
			default: ;
		endcase
	end

endmodule

// ===== hdl/crc_queue.sv =====
// short command queue between the front and the back end
module crc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  crc_pkg::cmd_t       push_cmd,
	input  logic                pop,
	output crc_pkg::cmd_t       head,
	output crc_pkg::q_status_t  q_status
);
	import crc_pkg::*;

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		if (p == QPTR_W'(QUEUE_DEPTH - 1))
			return '0;
		else
			return p + 1'b1;
	endfunction

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_cmd;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	assign head           = slot_q[rd_ptr_q];
	assign q_status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_status.empty = (count_q == '0);

endmodule

// ===== hdl/crc_back.sv =====
// back end: canvas memory, pixel sweep with squared distance test, read-out
`include "assert_macros.svh"

module crc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  crc_pkg::cmd_t       q_head,
	input  crc_pkg::q_status_t  q_status,
	output logic                pop,
	output logic                done,
	output logic [7:0]          pixel_value,
	output logic                bad_radius
);
	import crc_pkg::*;

	localparam int STEP_W     = SQ_W + 2;
	localparam int STEP_SHIFT = $clog2(2 * ONE_Q8);
	localparam int ONE_SQ     = ONE_Q8 * ONE_Q8;

	// setup products, one per cycle through the shared multiplier
	typedef enum logic [1:0] {
		MUL_R,
		MUL_RM,
		MUL_CX,
		MUL_CY
	} mul_step_t;

	back_state_t state_q;
	back_state_t state_d;
	mul_step_t   cnt_q;
	cmd_t        cmd_q;

	logic [SIDE_W-1:0]          x_q;
	logic [SIDE_W-1:0]          y_q;
	logic signed [DXY_W-1:0]    dx_q;
	logic signed [DXY_W-1:0]    dy_q;
	logic [SQ_W-1:0]            r2_q;
	logic [SQ_W-1:0]            rm2_q;
	logic [SQ_W-1:0]            cx2_q;
	logic [SQ_W-1:0]            dx2_q;
	logic [SQ_W-1:0]            dy2_q;

	logic signed [COORD_W-1:0]   rm;
	logic signed [COORD_W-1:0]   mul_a;
	logic signed [2*COORD_W-1:0] prod;
	logic [SQ_W-1:0]             sq;
	logic signed [STEP_W-1:0]    dx2_sum;
	logic signed [STEP_W-1:0]    dy2_sum;
	logic                        x_last;
	logic                        y_last;

	logic              vld_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [D2_W-1:0]   d2_s1;
	logic              thin;
	logic              covered;
	logic              border;
	logic              paint;
	logic              wr_en;

	logic [7:0] canvas_q [MEM_DEPTH];
	logic [7:0] rd_data_q;
	logic       done_q;
	logic [7:0] pixel_value_q;
	logic       bad_radius_q;

	// sequencer next state
	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!q_status.empty) begin
					pop = 1'b1;
					case (q_head.kind)
						CMD_CLEAR: state_d = BK_SWEEP;
						CMD_DRAW:  state_d = BK_MUL;
						CMD_READ:  state_d = BK_READ;
						default:   state_d = BK_FINISH;
					endcase
				end
			end
			BK_MUL: begin
				if (cnt_q == MUL_CY)
					state_d = BK_SWEEP;
			end
			BK_SWEEP: begin
				if (x_last && y_last)
					state_d = BK_DRAIN;
			end
			BK_DRAIN:  state_d = BK_FINISH;
			BK_READ:   state_d = BK_FINISH;
			BK_FINISH: state_d = BK_IDLE;
			default:   state_d = BK_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			cnt_q   <= MUL_R;
			vld_s1  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop)
				cnt_q <= MUL_R;
			else if (state_q == BK_MUL)
				cnt_q <= mul_step_t'(cnt_q + 1'b1);
			vld_s1 <= (state_q == BK_SWEEP);
			done_q <= (state_q == BK_FINISH);
		end
	end

	// shared multiplier operand select
	assign rm = cmd_q.radius - COORD_W'(ONE_Q8);

	always_comb begin
		case (cnt_q)
			MUL_R:   mul_a = cmd_q.radius;
			MUL_RM:  mul_a = rm;
			MUL_CX:  mul_a = cmd_q.cx;
			MUL_CY:  mul_a = cmd_q.cy;
			default: mul_a = cmd_q.radius;
		endcase
	end

	assign prod = mul_a * mul_a;
	assign sq   = prod[SQ_W-1:0];

	// next squares along a row and down a column: (d + 1.0)^2 = d^2 + 2d + 1.0
	assign dx2_sum = $signed({2'b00, dx2_q}) + ($signed(STEP_W'(dx_q)) <<< STEP_SHIFT)
		+ STEP_W'(ONE_SQ);
	assign dy2_sum = $signed({2'b00, dy2_q}) + ($signed(STEP_W'(dy_q)) <<< STEP_SHIFT)
		+ STEP_W'(ONE_SQ);

	assign x_last = (x_q == cmd_q.w_last);
	assign y_last = (y_q == cmd_q.h_last);

	// command, setup products and sweep counters
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= q_head;
			x_q   <= '0;
			y_q   <= '0;
		end else if (state_q == BK_MUL) begin
			case (cnt_q)
				MUL_R:  r2_q  <= sq;
				MUL_RM: rm2_q <= sq;
				MUL_CX: begin
					cx2_q <= sq;
					dx2_q <= sq;
				end
				MUL_CY: begin
					dy2_q <= sq;
					dx_q  <= -DXY_W'(cmd_q.cx);
					dy_q  <= -DXY_W'(cmd_q.cy);
				end
				default: ;
			endcase
		end else if (state_q == BK_SWEEP) begin
			if (x_last) begin
				x_q   <= '0;
				dx_q  <= -DXY_W'(cmd_q.cx);
				dx2_q <= cx2_q;
				if (!y_last) begin
					y_q   <= y_q + 1'b1;
					dy_q  <= dy_q + DXY_W'(ONE_Q8);
					dy2_q <= dy2_sum[SQ_W-1:0];
				end
			end else begin
				x_q   <= x_q + 1'b1;
				dx_q  <= dx_q + DXY_W'(ONE_Q8);
				dx2_q <= dx2_sum[SQ_W-1:0];
			end
		end
	end

	// pixel stage: address and squared distance
	always_ff @(posedge clk) begin
		addr_s1 <= {y_q, x_q};
		d2_s1   <= {1'b0, dx2_q} + {1'b0, dy2_q};
	end

	// coverage test on the staged pixel
	assign thin    = (cmd_q.radius < $signed(COORD_W'(ONE_Q8)));
	assign covered = (d2_s1 <= D2_W'(r2_q));
	assign border  = covered && (thin || d2_s1 > D2_W'(rm2_q));

	always_comb begin
		case (cmd_q.kind)
			CMD_CLEAR: paint = 1'b1;
			CMD_DRAW:  paint = cmd_q.outline ? border : covered;
			default:   paint = 1'b0;
		endcase
	end

	assign wr_en = vld_s1 && paint;

	// canvas memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en)
			canvas_q[addr_s1] <= cmd_q.color;
		rd_data_q <= canvas_q[{cmd_q.row, cmd_q.col}];
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == BK_FINISH) begin
			pixel_value_q <= (cmd_q.kind == CMD_READ) ? rd_data_q : '0;
			bad_radius_q  <= cmd_q.bad;
		end
	end

	assign done        = done_q;
	assign pixel_value = pixel_value_q;
	assign bad_radius  = bad_radius_q;

	// checks on the sequencer and the write path
	`CRC_ASSERT_NEXT(a_done_single, done_q, !done_q)
	`CRC_ASSERT_IMP(a_wr_in_sweep, wr_en, state_q == BK_SWEEP || state_q == BK_DRAIN)
	`CRC_ASSERT_IMP(a_pop_idle, pop, !q_status.empty && state_q == BK_IDLE)
	`CRC_ASSERT_NEXT(a_mul_to_sweep, state_q == BK_MUL && cnt_q == MUL_CY, state_q == BK_SWEEP)

endmodule

// ===== hdl/circle_raster_canvas.sv =====
// top level of the circle raster canvas
// Character canvas of up to 256 by 256 pixels with clear, circle draw and pixel
// read items. An item is taken when start is high and busy is low; up to two
// items wait in a queue, and busy rises only when that queue is full. Every item
// gives one result, shown for a single cycle with done high, and the receiver
// cannot stall it. A draw or a clear sweeps every pixel in use, one pixel a
// cycle; a draw first forms the squared radii and centre terms in setup steps
// that share one multiplier. The canvas memory is not cleared at reset: read
// only pixels that a clear or a draw has written. Configuration writes are taken
// at once, and are meant for times when no item is pending.
module circle_raster_canvas (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          op,
	input  logic [1:0]                          shape_kind,
	input  logic signed [crc_pkg::COORD_W-1:0]  center_x,
	input  logic signed [crc_pkg::COORD_W-1:0]  center_y,
	input  logic signed [crc_pkg::COORD_W-1:0]  radius,
	input  logic [7:0]                          color,
	input  logic [crc_pkg::SIDE_W-1:0]          pixel_column,
	input  logic [crc_pkg::SIDE_W-1:0]          pixel_row,
	input  logic                                cfg_wr_en,
	input  logic [crc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [crc_pkg::CFG_W-1:0]           cfg_data,
	output logic                                done,
	output logic [7:0]                          pixel_value,
	output logic                                bad_radius
);
	import crc_pkg::*;

	logic      push;
	logic      pop;
	cmd_t      push_cmd;
	cmd_t      head;
	q_status_t q_status;

	// intake and classification
	crc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.op           (op),
		.shape_kind   (shape_kind),
		.center_x     (center_x),
		.center_y     (center_y),
		.radius       (radius),
		.color        (color),
		.pixel_column (pixel_column),
		.pixel_row    (pixel_row),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.q_status     (q_status),
		.busy         (busy),
		.push         (push),
		.push_cmd     (push_cmd)
	);

	// command queue
	crc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_status (q_status)
	);

	// sweep engine and canvas memory
	crc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_head      (head),
		.q_status    (q_status),
		.pop         (pop),
		.done        (done),
		.pixel_value (pixel_value),
		.bad_radius  (bad_radius)
	);

endmodule

// ===== dv/circle_raster_canvas_checker.sv =====
// checker for the circle raster canvas: tracks the canvas, predicts each result and compares
`timescale 1ns / 100ps

module circle_raster_canvas_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                busy,
	input  logic [1:0]                          op,
	input  logic [1:0]                          shape_kind,
	input  logic signed [crc_pkg::COORD_W-1:0]  center_x,
	input  logic signed [crc_pkg::COORD_W-1:0]  center_y,
	input  logic signed [crc_pkg::COORD_W-1:0]  radius,
	input  logic [7:0]                          color,
	input  logic [crc_pkg::SIDE_W-1:0]          pixel_column,
	input  logic [crc_pkg::SIDE_W-1:0]          pixel_row,
	input  logic                                cfg_wr_en,
	input  logic [crc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [crc_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                done,
	input  logic [7:0]                          pixel_value,
	input  logic                                bad_radius,
	output int                                  results_pending,
	output int                                  mismatch_total
);
	import crc_pkg::*;

	typedef struct packed {
		logic [7:0] value;
		logic       bad;
	} canvas_answer_t;

	// own copy of the registers and of the canvas
	logic [CFG_W-1:0] width_model;
	logic [CFG_W-1:0] height_model;
	logic [7:0]       background_model;
	logic [7:0]       canvas_model [MEM_DEPTH];

	canvas_answer_t   awaited_answers [$];
	int               mismatches = 0;

	// size register as the block uses it: zero acts as one, oversize clamps
	function automatic int side_in_use(input logic [CFG_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_SIDE)
			return MAX_SIDE;
		return int'(v);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// squared distance test over every pixel in use, exact in Q.16
	task automatic paint_circle(input logic [1:0] kind, input longint cx, input longint cy,
			input longint r, input logic [7:0] ink);
		longint r2;
		longint rm2;
		longint dx;
		longint dy;
		longint d2;
		bit     thin;
		bit     covered;
		bit     border;
		int     w;
		int     h;
		w = side_in_use(width_model);
		h = side_in_use(height_model);
		r2 = r * r;
		rm2 = (r - ONE_Q8) * (r - ONE_Q8);
		thin = r < ONE_Q8;
		if (kind == SHAPE_OUTLINE || kind == SHAPE_FILLED) begin
			for (int y = 0; y < h; y++) begin
				dy = longint'(y) * ONE_Q8 - cy;
				for (int x = 0; x < w; x++) begin
					dx = longint'(x) * ONE_Q8 - cx;
					d2 = dx * dx + dy * dy;
					covered = d2 <= r2;
					border = covered && (thin || d2 > rm2);
					if ((kind == SHAPE_FILLED && covered) || (kind == SHAPE_OUTLINE && border))
						canvas_model[ADDR_W'(y * MAX_SIDE + x)] = ink;
				end
			end
		end
	endtask

	// apply the item on the ports to the canvas copy and give its answer
	task automatic run_canvas_op(output canvas_answer_t ans);
		int w;
		int h;
		w = side_in_use(width_model);
		h = side_in_use(height_model);
		ans = '0;
		case (op)
			OP_CLEAR: begin
				for (int y = 0; y < h; y++)
					for (int x = 0; x < w; x++)
						canvas_model[ADDR_W'(y * MAX_SIDE + x)] = background_model;
			end
			OP_DRAW: begin
				if (longint'(radius) <= 0)
					ans.bad = 1'b1;
				else
					paint_circle(shape_kind, longint'(center_x), longint'(center_y),
						longint'(radius), color);
			end
			OP_READ: begin
				if (int'(pixel_column) < w && int'(pixel_row) < h)
					ans.value = canvas_model[{pixel_row, pixel_column}];
			end
			default: begin
			end
		endcase
	endtask

	// watch results, register writes and accepted items at every edge
	always @(posedge clk or negedge arst_n) begin
		canvas_answer_t ans;
		canvas_answer_t want;
		if (!arst_n) begin
			width_model = CFG_W'(1);
			height_model = CFG_W'(1);
			background_model = BACKGROUND_RESET;
			awaited_answers.delete();
			results_pending <= 0;
		end else begin
			// results leave in item order
			if (done === 1'b1) begin
				if (awaited_answers.size() == 0) begin
					report_mismatch("result with no item waiting", 1, 0);
				end else begin
					want = awaited_answers.pop_front();
					if (pixel_value !== want.value)
						report_mismatch("pixel_value", int'(pixel_value), int'(want.value));
					if (bad_radius !== want.bad)
						report_mismatch("bad_radius", int'(bad_radius), int'(want.bad));
				end
			end
			// register writes
			if (cfg_wr_en === 1'b1) begin
				case (cfg_index)
					CFG_WIDTH:      width_model = cfg_data;
					CFG_HEIGHT:     height_model = cfg_data;
					CFG_BACKGROUND: background_model = cfg_data[7:0];
					default: begin
					end
				endcase
			end
			// accepted item
			if (start === 1'b1 && busy === 1'b0) begin
				run_canvas_op(ans);
				awaited_answers.push_back(ans);
			end
			results_pending <= awaited_answers.size();
		end
		mismatch_total <= mismatches;
	end

endmodule

// ===== dv/tb_circle_raster_canvas.sv =====
// testbench top for the circle raster canvas: clock, reset, item and register stimulus, verdict
`timescale 1ns / 100ps

module tb_circle_raster_canvas;
	import crc_pkg::*;

	localparam int CYCLE_LIMIT  = 1_200_000;
	localparam int IDLE_PERCENT = 23;
	localparam int COORD_MIN    = -(1 << (COORD_W - 1));
	localparam int COORD_MAX    = (1 << (COORD_W - 1)) - 1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam logic [1:0] OP_SPARE    = 2'd3;
	localparam logic [1:0] SHAPE_NONE  = 2'd2;
	localparam logic [1:0] SHAPE_SPARE = 2'd3;

	typedef struct packed {
		logic [1:0]                op;
		logic [1:0]                kind;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic signed [COORD_W-1:0] r;
		logic [7:0]                ink;
		logic [SIDE_W-1:0]         col;
		logic [SIDE_W-1:0]         row;
	} canvas_cmd_t;

	logic                        clk;
	logic                        arst_n;
	logic                        start;
	logic                        busy;
	logic [1:0]                  op;
	logic [1:0]                  shape_kind;
	logic signed [COORD_W-1:0]   center_x;
	logic signed [COORD_W-1:0]   center_y;
	logic signed [COORD_W-1:0]   radius;
	logic [7:0]                  color;
	logic [SIDE_W-1:0]           pixel_column;
	logic [SIDE_W-1:0]           pixel_row;
	logic                        cfg_wr_en;
	logic [CFG_IDX_W-1:0]        cfg_index;
	logic [CFG_W-1:0]            cfg_data;
	logic                        done;
	logic [7:0]                  pixel_value;
	logic                        bad_radius;

	int                          results_pending;
	int                          mismatch_total;
	int unsigned                 cycle_count = 0;

	// canvas size in use, for shaping the random items
	int width_now  = 1;
	int height_now = 1;
	bit no_idle    = 1'b0;
	int n_clear    = 0;
	int n_draw     = 0;
	int n_read     = 0;
	int n_spare    = 0;
	int n_settings = 1;

	circle_raster_canvas dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.shape_kind   (shape_kind),
		.center_x     (center_x),
		.center_y     (center_y),
		.radius       (radius),
		.color        (color),
		.pixel_column (pixel_column),
		.pixel_row    (pixel_row),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.done         (done),
		.pixel_value  (pixel_value),
		.bad_radius   (bad_radius)
	);

	circle_raster_canvas_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.op              (op),
		.shape_kind      (shape_kind),
		.center_x        (center_x),
		.center_y        (center_y),
		.radius          (radius),
		.color           (color),
		.pixel_column    (pixel_column),
		.pixel_row       (pixel_row),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.done            (done),
		.pixel_value     (pixel_value),
		.bad_radius      (bad_radius),
		.results_pending (results_pending),
		.mismatch_total  (mismatch_total)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("circle_raster_canvas verification failed");
			$finish;
		end
	end

	function automatic int side_of(input int v);
		if (v == 0)
			return 1;
		if (v > MAX_SIDE)
			return MAX_SIDE;
		return v;
	endfunction

	function automatic canvas_cmd_t plain_cmd(input logic [1:0] code);
		canvas_cmd_t c;
		c = '0;
		c.op = code;
		return c;
	endfunction

	function automatic canvas_cmd_t draw_cmd(input logic [1:0] kind, input int cx, input int cy,
			input int r, input logic [7:0] ink);
		canvas_cmd_t c;
		c = '0;
		c.op = OP_DRAW;
		c.kind = kind;
		c.cx = COORD_W'(cx);
		c.cy = COORD_W'(cy);
		c.r = COORD_W'(r);
		c.ink = ink;
		return c;
	endfunction

	function automatic canvas_cmd_t read_cmd(input int col, input int row);
		canvas_cmd_t c;
		c = '0;
		c.op = OP_READ;
		c.col = SIDE_W'(col);
		c.row = SIDE_W'(row);
		return c;
	endfunction

	// mostly well-formed draws and in-canvas reads, with some noise on every field
	function automatic canvas_cmd_t random_cmd();
		canvas_cmd_t c;
		int pick;
		int span;
		c = '0;
		c.ink = 8'($urandom_range(255));
		c.col = SIDE_W'($urandom_range(255));
		c.row = SIDE_W'($urandom_range(255));
		c.kind = 2'($urandom_range(3));
		c.cx = COORD_W'($urandom);
		c.cy = COORD_W'($urandom);
		c.r = COORD_W'($urandom);
		span = (width_now > height_now) ? width_now : height_now;
		pick = $urandom_range(99);
		if (pick < 10) begin
			c.op = OP_CLEAR;
		end else if (pick < 50) begin
			c.op = OP_DRAW;
			c.kind = ($urandom_range(9) == 0) ? 2'($urandom_range(SHAPE_NONE, SHAPE_SPARE))
				: 2'($urandom_range(SHAPE_FILLED));
			if ($urandom_range(9) != 0) begin
				c.cx = COORD_W'(int'($urandom_range(width_now * ONE_Q8 + 255)) - 128);
				c.cy = COORD_W'(int'($urandom_range(height_now * ONE_Q8 + 255)) - 128);
			end
			case ($urandom_range(15))
				0: c.r = '0;
				1: c.r = COORD_W'(-int'($urandom_range(1, -COORD_MIN)));
				2: c.r = COORD_W'($urandom);
				default: c.r = COORD_W'($urandom_range(1, span * ONE_Q8));
			endcase
		end else if (pick < 95) begin
			c.op = OP_READ;
			if ($urandom_range(99) < 85) begin
				c.col = SIDE_W'($urandom_range(width_now - 1));
				c.row = SIDE_W'($urandom_range(height_now - 1));
			end
		end else begin
			c.op = OP_SPARE;
		end
		return c;
	endfunction

	// present one item, idling first now and then; returns at the accepting edge
	task automatic send(input canvas_cmd_t c);
		if (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
		start <= 1'b1;
		op <= c.op;
		shape_kind <= c.kind;
		center_x <= c.cx;
		center_y <= c.cy;
		radius <= c.r;
		color <= c.ink;
		pixel_column <= c.col;
		pixel_row <= c.row;
		do @(posedge clk); while (busy !== 1'b0);
		case (c.op)
			OP_CLEAR: n_clear++;
			OP_DRAW:  n_draw++;
			OP_READ:  n_read++;
			default:  n_spare++;
		endcase
	endtask

	// stop sending and wait for every awaited result
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (results_pending != 0);
	endtask

	task automatic configure(input int w, input int h, input int bg, input bit spare);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_WIDTH;
		cfg_data <= CFG_W'(w);
		@(posedge clk);
		cfg_index <= CFG_HEIGHT;
		cfg_data <= CFG_W'(h);
		@(posedge clk);
		cfg_index <= CFG_BACKGROUND;
		cfg_data <= CFG_W'(bg);
		@(posedge clk);
		if (spare) begin
			cfg_index <= CFG_SPARE;
			cfg_data <= CFG_W'($urandom_range(511));
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
		width_now = side_of(w);
		height_now = side_of(h);
		n_settings++;
	endtask

	// stimulus
	initial begin
		int w;
		int h;
		arst_n = 1'b0;
		start = 1'b0;
		op = OP_CLEAR;
		shape_kind = SHAPE_OUTLINE;
		center_x = '0;
		center_y = '0;
		radius = '0;
		color = '0;
		pixel_column = '0;
		pixel_row = '0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_WIDTH;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: one pixel canvas, background code 32
		send(plain_cmd(OP_CLEAR));
		send(read_cmd(0, 0));
		send(read_cmd(5, 3));
		send(plain_cmd(OP_SPARE));
		settle();

		// full canvas, oversize width clamps and background drops its top bit;
		// this clear also leaves every pixel of the store written
		configure(511, 256, 9'h1AB, 1'b0);
		send(plain_cmd(OP_CLEAR));
		send(draw_cmd(SHAPE_FILLED, 128 * ONE_Q8, 128 * ONE_Q8, 100 * ONE_Q8, 8'h23));
		send(read_cmd(255, 255));
		send(read_cmd(128, 128));
		send(read_cmd(0, 0));
		send(read_cmd(200, 30));
		settle();

		// small canvas, directed cases
		configure(16, 12, 9'h02E, 1'b0);
		send(plain_cmd(OP_CLEAR));
		send(draw_cmd(SHAPE_OUTLINE, 8 * ONE_Q8, 6 * ONE_Q8, 5 * ONE_Q8, 8'h6F));
		send(read_cmd(13, 6));
		send(read_cmd(8, 6));
		send(draw_cmd(SHAPE_FILLED, 896, 704, 640, 8'hFF));
		send(read_cmd(3, 2));
		// radius below one: every inside pixel is border
		send(draw_cmd(SHAPE_OUTLINE, 2688, 2368, 192, 8'h00));
		// radius exactly one
		send(draw_cmd(SHAPE_OUTLINE, 1 * ONE_Q8, 10 * ONE_Q8, ONE_Q8, 8'h78));
		send(read_cmd(10, 9));
		send(read_cmd(1, 10));
		// non-positive radius is dropped whatever the kind
		send(draw_cmd(SHAPE_FILLED, 4 * ONE_Q8, 4 * ONE_Q8, 0, 8'h11));
		send(draw_cmd(SHAPE_OUTLINE, 4 * ONE_Q8, 4 * ONE_Q8, -1, 8'h12));
		send(draw_cmd(SHAPE_NONE, 4 * ONE_Q8, 4 * ONE_Q8, COORD_MIN, 8'h13));
		// unknown kinds paint nothing
		send(draw_cmd(SHAPE_NONE, 4 * ONE_Q8, 4 * ONE_Q8, 4 * ONE_Q8, 8'h14));
		send(draw_cmd(SHAPE_SPARE, 4 * ONE_Q8, 4 * ONE_Q8, 4 * ONE_Q8, 8'h15));
		// coordinate and radius extremes
		send(draw_cmd(SHAPE_FILLED, COORD_MIN, COORD_MAX, COORD_MAX, 8'h55));
		send(draw_cmd(SHAPE_OUTLINE, COORD_MAX, COORD_MIN, COORD_MAX, 8'hAA));
		send(draw_cmd(SHAPE_FILLED, 0, 0, COORD_MAX, 8'h5A));
		send(plain_cmd(OP_SPARE));
		send(read_cmd(15, 11));
		send(read_cmd(16, 0));
		send(read_cmd(0, 12));
		send(read_cmd(255, 255));
		settle();

		// random items over several settings, one stretch with no idling
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin
					w = 0;
					h = 9;
				end
				1: begin
					w = 300;
					h = 2;
				end
				2: begin
					w = 1;
					h = 0;
				end
				default: begin
					w = $urandom_range(2, 24);
					h = $urandom_range(2, 24);
				end
			endcase
			configure(w, h, $urandom_range(511), 1'b1);
			no_idle = (p == 3);
			repeat (11) send(random_cmd());
			settle();
		end

		repeat (20) @(posedge clk);
		$display("covered %0d items: %0d clears, %0d draws, %0d reads, %0d with the unused op",
			n_clear + n_draw + n_read + n_spare, n_clear, n_draw, n_read, n_spare);
		$display("over %0d canvas settings from one pixel up to the full 256 by 256",
			n_settings);
		if (mismatch_total == 0)
			$display("circle_raster_canvas verification clean");
		else
			$display("circle_raster_canvas verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/crc_pkg.sv
hdl/crc_front.sv
hdl/crc_queue.sv
hdl/crc_back.sv
hdl/circle_raster_canvas.sv
dv/circle_raster_canvas_checker.sv
dv/tb_circle_raster_canvas.sv
